>>> design/kpr_pkg.sv
// Package for the knock pattern recorder: beat types, command and status codes,
// register indexes, phase and sequencer enums. No dependencies.
package kpr_pkg;

  // Fixed field widths
  localparam int SAMPLE_W = 8;
  localparam int PAUSE_W  = 8;
  localparam int THR_W    = 9;
  localparam int MINTAP_W = 4;
  localparam int IDX_W    = 5;
  localparam int VAL_W    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  // Command codes
  localparam logic [1:0] FUNC_START   = 2'd0;
  localparam logic [1:0] FUNC_SAMPLE  = 2'd1;
  localparam logic [1:0] FUNC_PAUSE   = 2'd2;
  localparam logic [1:0] FUNC_TIMEOUT = 2'd3;

  // Result kinds and status codes
  localparam logic KIND_BEEP = 1'b0;
  localparam logic KIND_DONE = 1'b1;
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_FAIL    = 2'd1;
  localparam logic [1:0] STAT_TIMEOUT = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_THR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_MIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_MAX = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_TAPS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_TO  = 3'd4;

  // Register reset values
  localparam logic [THR_W-1:0]    RST_TAP_THR   = 9'd40;
  localparam logic [PAUSE_W-1:0]  RST_PAUSE_MIN = 8'd2;
  localparam logic [PAUSE_W-1:0]  RST_PAUSE_MAX = 8'd50;
  localparam logic [MINTAP_W-1:0] RST_MIN_TAPS  = 4'd2;
  localparam logic [PAUSE_W-1:0]  RST_START_TO  = 8'd10;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WAIT = 2'd1,
    PH_REC  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    S_READY = 2'd0,
    S_READ  = 2'd1,
    S_LOAD  = 2'd2,
    S_DIV   = 2'd3
  } seq_state_t;

  typedef struct packed {
    logic [1:0]          func;
    logic [SAMPLE_W-1:0] z_sample;
  } in_item_t;

  typedef struct packed {
    logic             kind;
    logic [1:0]       status;
    logic [IDX_W-1:0] index;
    logic [VAL_W-1:0] value;
    logic             last;
  } out_item_t;

endpackage

>>> design/knock_pattern_recorder_core.sv
// Knock pattern recorder core: tap detection, pause recording in an on-chip
// store and normalized playback through a bit-serial divider.
// Depends on kpr_pkg.
//
// Usage:
//  - Commands enter on in_data when start is high and busy is low. func selects
//    start, accelerometer sample, pause tick or timeout tick.
//  - Results leave on out_data, each marked by out_valid for exactly one cycle;
//    the receiver cannot hold them off.
//  - Registers are written on the cfg channel (cfg_ready is always high) and
//    must be changed only while busy is low and no result is pending.
//  - A command's beep, failure or timeout result appears in the cycle after it is
//    accepted; busy stays low unless the command starts playback, so the next
//    command can follow at once.
//  - A successful recording plays back SEQ_LEN results. Each entry passes through
//    one pause store read, one load and 8 steps of the one-bit-per-cycle divider
//    that forms p*255/longest; busy is high until the last entry is produced.
//  - Entries past the fill count read as zero, so starting a recording needs no
//    clearing pass over the store.
//  - Reset returns the registers to their defaults and the recorder to idle.
module knock_pattern_recorder_core #(
  parameter int SEQ_LEN = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  kpr_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  output kpr_pkg::out_item_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [kpr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [kpr_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int TC_W   = $clog2(SEQ_LEN + 2);
  localparam int SLOT_W = $clog2(SEQ_LEN);
  localparam int CMP_W  = (TC_W > kpr_pkg::MINTAP_W) ? TC_W : kpr_pkg::MINTAP_W;
  localparam int PW     = kpr_pkg::PAUSE_W;

  // Configuration registers
  logic [kpr_pkg::THR_W-1:0]    cfg_thr_r;
  logic [PW-1:0]                cfg_pmin_r;
  logic [PW-1:0]                cfg_pmax_r;
  logic [kpr_pkg::MINTAP_W-1:0] cfg_min_taps_r;
  logic [PW-1:0]                cfg_start_to_r;

  // Recorder state
  kpr_pkg::phase_t     phase_r, phase_nxt;
  kpr_pkg::seq_state_t state_r, state_nxt;
  logic [kpr_pkg::SAMPLE_W-1:0] prev_sample_r, prev_sample_nxt;
  logic signed [8:0]   prev_delta_r, prev_delta_nxt;
  logic [TC_W-1:0]     tap_count_r, tap_count_nxt;
  logic [PW-1:0]       longest_r, longest_nxt;
  logic [PW-1:0]       pause_r, pause_nxt;
  logic [PW-1:0]       timeout_r, timeout_nxt;

  // Playback sequencer and divider
  logic [SLOT_W-1:0]   elem_r, elem_nxt;
  logic [2:0]          step_r, step_nxt;
  logic [PW-1:0]       div_rem_r, div_rem_nxt;
  logic [PW-1:0]       div_num_r, div_num_nxt;

  // Output register
  logic                out_valid_r, out_valid_nxt;
  kpr_pkg::out_item_t  out_data_r, out_data_nxt;

  // Pause store
  logic [PW-1:0]       store_mem [SEQ_LEN];
  logic [PW-1:0]       rd_data_r;
  logic                mem_we;
  logic [SLOT_W-1:0]   mem_wa;
  logic [PW-1:0]       mem_wd;

  // Datapath helpers
  logic                accept;
  logic                go_seq;
  logic                do_sample;
  logic signed [8:0]   delta;
  logic signed [9:0]   dd;
  logic signed [9:0]   neg_dd;
  logic [8:0]          mag;
  logic                hit;
  logic [PW-1:0]       pc_eff;
  logic [PW-1:0]       to_dec;
  logic [TC_W-1:0]     tc_inc;
  logic                seq_last;
  logic                entry_ok;
  logic [2*PW-1:0]     num;
  logic [PW:0]         trial;
  logic                qbit;
  logic [PW-1:0]       quot;

  assign accept = start && !busy;

  // Second difference of the sample stream
  assign delta  = $signed({1'b0, in_data.z_sample}) - $signed({1'b0, prev_sample_r});
  assign dd     = $signed({delta[8], delta}) - $signed({prev_delta_r[8], prev_delta_r});
  assign neg_dd = -dd;
  assign mag    = dd[9] ? neg_dd[8:0] : dd[8:0];
  assign hit    = mag >= cfg_thr_r;

  // Pause count after this command's tick, saturating and frozen above pause_max
  assign pc_eff = (in_data.func == kpr_pkg::FUNC_PAUSE && pause_r <= cfg_pmax_r &&
                   pause_r != {PW{1'b1}}) ? pause_r + 1'b1 : pause_r;
  assign to_dec = (timeout_r != '0) ? timeout_r - 1'b1 : timeout_r;
  assign tc_inc = tap_count_r + 1'b1;

  // Playback helpers: entries beyond the fill count read as zero
  assign seq_last = (elem_r == SLOT_W'(SEQ_LEN - 1));
  assign entry_ok = TC_W'(elem_r) < TC_W'(tap_count_r - 1'b1);
  assign num      = entry_ok ? ({rd_data_r, {PW{1'b0}}} - {{PW{1'b0}}, rd_data_r}) : '0;
  assign trial    = {div_rem_r, div_num_r[PW-1]};
  assign qbit     = trial >= {1'b0, longest_r};
  assign quot     = {div_num_r[PW-2:0], qbit};

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_thr_r      <= kpr_pkg::RST_TAP_THR;
      cfg_pmin_r     <= kpr_pkg::RST_PAUSE_MIN;
      cfg_pmax_r     <= kpr_pkg::RST_PAUSE_MAX;
      cfg_min_taps_r <= kpr_pkg::RST_MIN_TAPS;
      cfg_start_to_r <= kpr_pkg::RST_START_TO;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        kpr_pkg::CFG_TAP_THR:   cfg_thr_r      <= cfg_data;
        kpr_pkg::CFG_PAUSE_MIN: cfg_pmin_r     <= cfg_data[PW-1:0];
        kpr_pkg::CFG_PAUSE_MAX: cfg_pmax_r     <= cfg_data[PW-1:0];
        kpr_pkg::CFG_MIN_TAPS:  cfg_min_taps_r <= cfg_data[kpr_pkg::MINTAP_W-1:0];
        kpr_pkg::CFG_START_TO:  cfg_start_to_r <= cfg_data[PW-1:0];
        default: ;
      endcase
    end
  end

  // Command handling and playback datapath
  always_comb begin
    phase_nxt       = phase_r;
    prev_sample_nxt = prev_sample_r;
    prev_delta_nxt  = prev_delta_r;
    tap_count_nxt   = tap_count_r;
    longest_nxt     = longest_r;
    pause_nxt       = pause_r;
    timeout_nxt     = timeout_r;
    elem_nxt        = elem_r;
    step_nxt        = step_r;
    div_rem_nxt     = div_rem_r;
    div_num_nxt     = div_num_r;
    out_valid_nxt   = 1'b0;
    out_data_nxt    = out_data_r;
    mem_we          = 1'b0;
    mem_wa          = SLOT_W'(tap_count_r - 1'b1);
    mem_wd          = pc_eff;
    go_seq          = 1'b0;
    do_sample       = 1'b0;

    if (accept) begin
      if (in_data.func == kpr_pkg::FUNC_START) begin
        // Arm: drop the previous recording and load the timeout
        prev_sample_nxt = '0;
        prev_delta_nxt  = '0;
        tap_count_nxt   = '0;
        longest_nxt     = '0;
        pause_nxt       = '0;
        timeout_nxt     = cfg_start_to_r;
        phase_nxt       = kpr_pkg::PH_WAIT;
        if (cfg_start_to_r == '0) begin
          phase_nxt     = kpr_pkg::PH_IDLE;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{kind: kpr_pkg::KIND_DONE, status: kpr_pkg::STAT_TIMEOUT,
                            index: '0, value: '0, last: 1'b1};
        end
      end else begin
        case (phase_r)
          kpr_pkg::PH_WAIT: begin
            if (in_data.func == kpr_pkg::FUNC_SAMPLE) begin
              do_sample = 1'b1;
            end else if (in_data.func == kpr_pkg::FUNC_TIMEOUT) begin
              timeout_nxt = to_dec;
              if (to_dec == '0) begin
                phase_nxt     = kpr_pkg::PH_IDLE;
                out_valid_nxt = 1'b1;
                out_data_nxt  = '{kind: kpr_pkg::KIND_DONE,
                                  status: kpr_pkg::STAT_TIMEOUT,
                                  index: '0, value: '0, last: 1'b1};
              end
            end
          end
          kpr_pkg::PH_REC: begin
            pause_nxt = pc_eff;
            if (pc_eff > cfg_pmax_r) begin
              // Gap too long: end the recording
              pause_nxt = '0;
              phase_nxt = kpr_pkg::PH_IDLE;
              if (CMP_W'(tap_count_r) <= CMP_W'(cfg_min_taps_r)) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = '{kind: kpr_pkg::KIND_DONE, status: kpr_pkg::STAT_FAIL,
                                  index: '0, value: '0, last: 1'b1};
              end else begin
                go_seq = 1'b1;
              end
            end else if (in_data.func == kpr_pkg::FUNC_SAMPLE) begin
              do_sample = 1'b1;
            end
          end
          default: ;
        endcase
      end

      // Tap detection and pause capture
      if (do_sample) begin
        prev_sample_nxt = in_data.z_sample;
        prev_delta_nxt  = delta;
        if (hit) begin
          if (tap_count_r == '0) begin
            pause_nxt     = '0;
            tap_count_nxt = TC_W'(1);
            phase_nxt     = kpr_pkg::PH_REC;
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{kind: kpr_pkg::KIND_BEEP, status: kpr_pkg::STAT_OK,
                              index: '0, value: '0, last: 1'b1};
          end else if (pc_eff > cfg_pmin_r) begin
            mem_we        = 1'b1;
            tap_count_nxt = tc_inc;
            if (pc_eff > longest_r) begin
              longest_nxt = pc_eff;
            end
            pause_nxt     = '0;
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{kind: kpr_pkg::KIND_BEEP, status: kpr_pkg::STAT_OK,
                              index: kpr_pkg::IDX_W'(tap_count_r), value: '0,
                              last: !(tap_count_r >= TC_W'(SEQ_LEN))};
            if (tap_count_r >= TC_W'(SEQ_LEN)) begin
              phase_nxt = kpr_pkg::PH_IDLE;
              go_seq    = 1'b1;
            end
          end else begin
            pause_nxt = '0;
          end
        end
      end

      if (go_seq) begin
        elem_nxt = '0;
      end
    end

    // Playback: load the divider, then one quotient bit per cycle
    case (state_r)
      kpr_pkg::S_LOAD: begin
        div_rem_nxt = num[2*PW-1:PW];
        div_num_nxt = num[PW-1:0];
        step_nxt    = '0;
      end
      kpr_pkg::S_DIV: begin
        div_rem_nxt = qbit ? PW'(trial - {1'b0, longest_r}) : trial[PW-1:0];
        div_num_nxt = quot;
        step_nxt    = step_r + 1'b1;
        if (step_r == 3'd7) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{kind: kpr_pkg::KIND_DONE, status: kpr_pkg::STAT_OK,
                            index: kpr_pkg::IDX_W'(elem_r),
                            value: (longest_r == '0) ? '0 : quot,
                            last: seq_last};
          if (!seq_last) begin
            elem_nxt = elem_r + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      kpr_pkg::S_READY: begin
        if (accept && go_seq) begin
          state_nxt = kpr_pkg::S_READ;
        end
      end
      kpr_pkg::S_READ:  state_nxt = kpr_pkg::S_LOAD;
      kpr_pkg::S_LOAD:  state_nxt = kpr_pkg::S_DIV;
      kpr_pkg::S_DIV: begin
        if (step_r == 3'd7) begin
          state_nxt = seq_last ? kpr_pkg::S_READY : kpr_pkg::S_READ;
        end
      end
      default: state_nxt = kpr_pkg::S_READY;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    case (state_r)
      kpr_pkg::S_READY: busy = 1'b0;
      default:          busy = 1'b1;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= kpr_pkg::PH_IDLE;
      state_r       <= kpr_pkg::S_READY;
      prev_sample_r <= '0;
      prev_delta_r  <= '0;
      tap_count_r   <= '0;
      longest_r     <= '0;
      pause_r       <= '0;
      timeout_r     <= '0;
      elem_r        <= '0;
      step_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      state_r       <= state_nxt;
      prev_sample_r <= prev_sample_nxt;
      prev_delta_r  <= prev_delta_nxt;
      tap_count_r   <= tap_count_nxt;
      longest_r     <= longest_nxt;
      pause_r       <= pause_nxt;
      timeout_r     <= timeout_nxt;
      elem_r        <= elem_nxt;
      step_r        <= step_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    div_rem_r  <= div_rem_nxt;
    div_num_r  <= div_num_nxt;
    out_data_r <= out_data_nxt;
  end

  // Pause store: one write port, registered read of the playback entry
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= store_mem[elem_r];
  end

`ifndef ASSERT_OFF
  // Divider remainder stays below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == kpr_pkg::S_DIV && longest_r != '0) |-> (div_rem_r < longest_r))
    else $error("divider remainder not below longest pause");

  // Playback runs only with the recorder back in idle
  a_seq_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != kpr_pkg::S_READY) |-> (phase_r == kpr_pkg::PH_IDLE))
    else $error("playback while recording");

  // A non-final playback result leaves the sequencer running
  a_seq_more: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.kind == kpr_pkg::KIND_DONE &&
     out_data.status == kpr_pkg::STAT_OK && !out_data.last) |-> busy)
    else $error("playback stopped before the last entry");

  // A start command never launches playback
  a_start_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.func == kpr_pkg::FUNC_START) |=> !busy)
    else $error("start command raised busy");
`endif

endmodule
